// ===== hw/rtl/lfd_pkg.sv =====
// ============================================================================
// lfd_pkg
// Shared types and constants for the frame decompressor.
// ============================================================================
`default_nettype none

package lfd_pkg;

    localparam int FlagsPerFrame  = 12;
    localparam int WindowSize     = 256;
    localparam int BytesPerResult = 8;
    localparam int HistAw         = $clog2(WindowSize);

    // Parse phases of the compressed stream.
    localparam logic [2:0] PH_MASK_LO = 3'd0;
    localparam logic [2:0] PH_MASK_HI = 3'd1;
    localparam logic [2:0] PH_SYMBOLS = 3'd2;
    localparam logic [2:0] PH_REC_LEN = 3'd3;
    localparam logic [2:0] PH_REC_OFF = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;
    localparam logic [2:0] PH_HALT    = 3'd6;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_COUNT = 2'd1;
    localparam logic [1:0] ST_BAD_OFF   = 2'd2;
    localparam logic [1:0] ST_TRUNC     = 2'd3;

    typedef struct packed {
        logic [7:0] compressed_byte;
        logic       end_of_stream;
    } cmp_item_t;

    typedef struct packed {
        logic [63:0] data_bytes;
        logic [3:0]  byte_count;
        logic        last_of_run;
        logic        stream_done;
        logic [1:0]  status;
        logic [15:0] total_count;
    } dec_item_t;

    typedef struct packed {
        logic load;
        logic parse;
        logic rd;
        logic emit_copy;
        logic emit_sym;
        logic adv_done;
        logic finish;
    } lfd_cmd_t;

    typedef struct packed {
        logic parse_adv;
        logic parse_copy;
        logic len_zero;
        logic copy_last;
        logic adv_emit;
        logic emit_ok;
        logic need_push;
        logic out_free;
    } lfd_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lfd_ram.sv =====
// ============================================================================
// lfd_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module lfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata_reg
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lfd_ctrl.sv =====
// ============================================================================
// lfd_ctrl
// Sequencer that steps one compressed item through parse, copy and flush.
// ============================================================================
`default_nettype none

module lfd_ctrl
    import lfd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmp_valid,
    output logic           cmp_stall,
    input  wire lfd_stat_t st,
    output lfd_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PARSE = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_WR    = 3'd3;
    localparam logic [2:0] S_SYM   = 3'd4;
    localparam logic [2:0] S_ADV   = 3'd5;
    localparam logic [2:0] S_END   = 3'd6;

    logic [2:0] state_reg, state_next;

    assign cmp_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmp_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PARSE;
                end
            end
            S_PARSE:
            begin
                cmd.parse = 1'b1;
                if (st.parse_adv)
                    state_next = S_ADV;
                else if (st.parse_copy)
                    state_next = st.len_zero ? S_SYM : S_RD;
                else
                    state_next = S_END;
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                if (st.emit_ok)
                begin
                    cmd.emit_copy = 1'b1;
                    state_next    = st.copy_last ? S_SYM : S_RD;
                end
            end
            S_SYM:
            begin
                if (st.emit_ok)
                begin
                    cmd.emit_sym = 1'b1;
                    state_next   = S_ADV;
                end
            end
            S_ADV:
            begin
                if (st.adv_emit)
                begin
                    cmd.emit_sym = st.emit_ok;
                end
                else
                begin
                    cmd.adv_done = 1'b1;
                    state_next   = S_END;
                end
            end
            S_END:
            begin
                if (!st.need_push || st.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lfd_dp.sv =====
// ============================================================================
// lfd_dp
// Datapath: frame fields, symbol store, history window, packer and output.
// ============================================================================
`default_nettype none

module lfd_dp
    import lfd_pkg::*;
#(
    parameter int FLAGS_PER_FRAME  = FlagsPerFrame,
    parameter int BYTES_PER_RESULT = BytesPerResult
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cmp_item_t cmp_item,
    input  wire lfd_cmd_t  cmd,
    output lfd_stat_t      st,
    output logic           dec_valid,
    input  wire logic      dec_stall,
    output dec_item_t      dec_item
);

    localparam int SW = (FLAGS_PER_FRAME > 1) ? $clog2(FLAGS_PER_FRAME) : 1;
    localparam logic [3:0] FLAGS_N = 4'(FLAGS_PER_FRAME);
    localparam logic [3:0] BPR_N   = 4'(BYTES_PER_RESULT);

    logic [7:0]  byte_reg;
    logic        eos_reg;
    logic [2:0]  phase_reg;
    logic [15:0] mask_reg;
    logic [7:0]  sym_store [FLAGS_PER_FRAME];
    logic [3:0]  sym_idx_reg;
    logic [3:0]  flag_idx_reg;
    logic [7:0]  pend_reg;
    logic [HistAw-1:0] hp_reg;
    logic [15:0] prod_reg;
    logic [1:0]  err_reg;
    logic [63:0] acc_reg;
    logic [3:0]  acc_n_reg;
    logic        out_valid_reg;
    dec_item_t   out_item_reg;

    logic [7:0]  hist_rdata;
    logic [3:0]  cnt;
    logic        acc_full;
    logic        do_emit;
    logic [7:0]  emit_byte;
    logic [1:0]  final_err;
    logic        off_ok;

    assign cnt       = mask_reg[15:12];
    assign acc_full  = (acc_n_reg == BPR_N);
    assign do_emit   = cmd.emit_copy || cmd.emit_sym;
    assign emit_byte = cmd.emit_copy ? hist_rdata : sym_store[flag_idx_reg[SW-1:0]];
    assign off_ok    = (byte_reg != 8'd0) && ({8'd0, byte_reg} <= prod_reg);
    assign final_err = (eos_reg && (err_reg == ST_OK) && (phase_reg != PH_MASK_LO)
                        && (phase_reg != PH_DONE)) ? ST_TRUNC : err_reg;

    always_comb
    begin
        st            = '0;
        st.parse_adv  = (phase_reg == PH_SYMBOLS) && (sym_idx_reg == FLAGS_N - 4'd1);
        st.parse_copy = (phase_reg == PH_REC_OFF) && off_ok;
        st.len_zero   = (pend_reg == 8'd0);
        st.copy_last  = (pend_reg == 8'd1);
        st.adv_emit   = (flag_idx_reg < cnt) && !mask_reg[flag_idx_reg];
        st.out_free   = !out_valid_reg || !dec_stall;
        st.emit_ok    = !acc_full || st.out_free;
        st.need_push  = (acc_n_reg != 4'd0) || eos_reg;
    end

    lfd_ram #(
        .WIDTH(8),
        .DEPTH(WindowSize)
    ) u_hist (
        .clk      (clk),
        .we       (do_emit),
        .waddr    (hp_reg),
        .wdata    (emit_byte),
        .re       (cmd.rd),
        .raddr    (hp_reg - byte_reg[HistAw-1:0]),
        .rdata_reg(hist_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= cmp_item.compressed_byte;
            eos_reg  <= cmp_item.end_of_stream;
        end
        if (cmd.parse && (phase_reg == PH_SYMBOLS))
        begin
            sym_store[sym_idx_reg[SW-1:0]] <= byte_reg;
        end
        if (do_emit)
        begin
            if (acc_full)
                acc_reg <= {56'd0, emit_byte};
            else
                acc_reg <= acc_reg | ({56'd0, emit_byte} << {acc_n_reg, 3'd0});
        end
        else if (cmd.finish)
        begin
            acc_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_MASK_LO;
            mask_reg      <= '0;
            sym_idx_reg   <= '0;
            flag_idx_reg  <= '0;
            pend_reg      <= '0;
            hp_reg        <= '0;
            prod_reg      <= '0;
            err_reg       <= ST_OK;
            acc_n_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.parse)
            begin
                case (phase_reg)
                    PH_MASK_LO:
                    begin
                        mask_reg  <= {8'd0, byte_reg};
                        phase_reg <= PH_MASK_HI;
                    end
                    PH_MASK_HI:
                    begin
                        mask_reg[15:8] <= byte_reg;
                        flag_idx_reg   <= '0;
                        sym_idx_reg    <= '0;
                        if (byte_reg[7:4] > FLAGS_N)
                        begin
                            err_reg   <= ST_BAD_COUNT;
                            phase_reg <= PH_HALT;
                        end
                        else if (byte_reg[7:4] == 4'd0)
                            phase_reg <= PH_DONE;
                        else
                            phase_reg <= PH_SYMBOLS;
                    end
                    PH_SYMBOLS:
                    begin
                        if (st.parse_adv)
                        begin
                            sym_idx_reg  <= '0;
                            flag_idx_reg <= '0;
                        end
                        else
                            sym_idx_reg <= sym_idx_reg + 4'd1;
                    end
                    PH_REC_LEN:
                    begin
                        pend_reg  <= byte_reg;
                        phase_reg <= PH_REC_OFF;
                    end
                    PH_REC_OFF:
                    begin
                        if (!off_ok)
                        begin
                            err_reg   <= ST_BAD_OFF;
                            phase_reg <= PH_HALT;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (do_emit)
            begin
                hp_reg <= hp_reg + 1'b1;
                if (prod_reg != 16'hFFFF)
                    prod_reg <= prod_reg + 16'd1;
                acc_n_reg <= acc_full ? 4'd1 : acc_n_reg + 4'd1;
                if (cmd.emit_copy)
                    pend_reg <= pend_reg - 8'd1;
                if (cmd.emit_sym)
                    flag_idx_reg <= flag_idx_reg + 4'd1;
            end

            if (cmd.adv_done)
            begin
                if (flag_idx_reg < cnt)
                    phase_reg <= PH_REC_LEN;
                else if (cnt == FLAGS_N)
                begin
                    flag_idx_reg <= '0;
                    phase_reg    <= PH_MASK_LO;
                end
                else
                    phase_reg <= PH_DONE;
            end

            // Output register: a full packer is pushed when the next byte
            // arrives, a partial one (or the stream end) at the finish step.
            if ((do_emit && acc_full) || (cmd.finish && st.need_push))
                out_valid_reg <= 1'b1;
            else if (!dec_stall)
                out_valid_reg <= 1'b0;

            if (cmd.finish)
            begin
                acc_n_reg <= '0;
                if (eos_reg)
                begin
                    phase_reg    <= PH_MASK_LO;
                    mask_reg     <= '0;
                    sym_idx_reg  <= '0;
                    flag_idx_reg <= '0;
                    pend_reg     <= '0;
                    hp_reg       <= '0;
                    prod_reg     <= '0;
                    err_reg      <= ST_OK;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_emit && acc_full)
        begin
            out_item_reg.data_bytes  <= acc_reg;
            out_item_reg.byte_count  <= acc_n_reg;
            out_item_reg.last_of_run <= 1'b0;
            out_item_reg.stream_done <= 1'b0;
            out_item_reg.status      <= err_reg;
            out_item_reg.total_count <= prod_reg;
        end
        else if (cmd.finish && st.need_push)
        begin
            out_item_reg.data_bytes  <= acc_reg;
            out_item_reg.byte_count  <= acc_n_reg;
            out_item_reg.last_of_run <= 1'b1;
            out_item_reg.stream_done <= eos_reg;
            out_item_reg.status      <= final_err;
            out_item_reg.total_count <= prod_reg;
        end
    end

    assign dec_valid = out_valid_reg;
    assign dec_item  = out_item_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lz_frame_decompressor.sv =====
// ============================================================================
// lz_frame_decompressor
// Streaming LZ77-style frame decoder with a 256-byte history window.
// ============================================================================
// The block takes one compressed byte per item and returns zero or more
// packed results of up to BYTES_PER_RESULT decoded bytes each. A header,
// symbol or record-length byte is loaded, parsed and then finished. A record
// offset byte triggers the copy, which runs through the history RAM byte by
// byte: a registered read, then the write and the packing. The record's own
// literal symbol follows the copy, and after it any literal symbols up to the
// next record. Results wait in an output register; when it is still held by
// the consumer, the copy pauses at the next full packer. The history RAM
// needs no clearing after reset, since the offset check keeps every copy
// inside bytes already written in this stream.
`default_nettype none

module lz_frame_decompressor
    import lfd_pkg::*;
#(
    parameter int FLAGS_PER_FRAME  = FlagsPerFrame,
    parameter int BYTES_PER_RESULT = BytesPerResult
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmp_valid,
    output logic           cmp_stall,
    input  wire cmp_item_t cmp_item,
    output logic           dec_valid,
    input  wire logic      dec_stall,
    output dec_item_t      dec_item
);

    lfd_cmd_t  cmd;
    lfd_stat_t st;

    // The sequencer decides which step runs each cycle.
    lfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmp_valid(cmp_valid),
        .cmp_stall(cmp_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // The datapath holds all stream state, the window and the packer.
    lfd_dp #(
        .FLAGS_PER_FRAME (FLAGS_PER_FRAME),
        .BYTES_PER_RESULT(BYTES_PER_RESULT)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmp_item (cmp_item),
        .cmd      (cmd),
        .st       (st),
        .dec_valid(dec_valid),
        .dec_stall(dec_stall),
        .dec_item (dec_item)
    );

    // A result never claims more bytes than the packer holds.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid |-> (dec_item.byte_count <= 4'(BYTES_PER_RESULT)))
        else $error("result byte count exceeds packer size");

    // The end of a stream always closes the run of its item.
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (dec_valid && dec_item.stream_done) |-> dec_item.last_of_run)
        else $error("stream end on a result that is not last");

    // Only the final result of an item may be partial.
    a_mid_full: assert property (@(posedge clk) disable iff (!rst_n)
        (dec_valid && !dec_item.last_of_run)
            |-> (dec_item.byte_count == 4'(BYTES_PER_RESULT)))
        else $error("partial result in the middle of a run");

endmodule

`default_nettype wire

// ===== tb/sv/tb_lz_frame_decompressor.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_lz_frame_decompressor
// Self-checking testbench for the streaming LZ frame decompressor.
// ============================================================================
// A queue of compressed stream items is filled by an initial block. A clocked
// driver sends them with random gaps, and a clocked monitor compares every
// decoded result with the predicted results, oldest first. The prediction is
// worked out when an item is accepted, by a decoder model kept in this file.
// ============================================================================
`default_nettype none

module tb_lz_frame_decompressor;
    import lfd_pkg::*;

    localparam int CycleLimit = 2000000;
    localparam int DrainCycles = 600;

    logic      clk;
    logic      rst_n;
    logic      cmp_valid;
    logic      cmp_stall;
    cmp_item_t cmp_item;
    logic      dec_valid;
    logic      dec_stall;
    dec_item_t dec_item;

    lz_frame_decompressor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmp_valid (cmp_valid),
        .cmp_stall (cmp_stall),
        .cmp_item  (cmp_item),
        .dec_valid (dec_valid),
        .dec_stall (dec_stall),
        .dec_item  (dec_item)
    );

    // Items waiting to be sent, and decoded results waiting to be seen.
    cmp_item_t pending_bytes[$];
    dec_item_t expected_output[$];
    // Index in pending_bytes at which the sender waits for a full drain.
    int        drain_point;
    int        error_count;
    int        cycle_count;
    bit        quiet_idle;
    bit        stimulus_built;

    // Decoder model state.
    logic [2:0]  dm_phase;
    logic [15:0] dm_mask;
    logic [7:0]  dm_symbols[FlagsPerFrame];
    int          dm_sym_idx;
    int          dm_flag_idx;
    logic [7:0]  dm_len;
    logic [7:0]  dm_hist[WindowSize];
    logic [7:0]  dm_hist_ptr;
    int          dm_produced;
    logic [1:0]  dm_status;
    // Packing of the bytes caused by one item.
    logic [63:0] pk_bytes;
    int          pk_n;
    dec_item_t   step_results[$];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int frame_count_of(logic [15:0] mask);
        return int'(mask[15:12]);
    endfunction

    task automatic flush_packer();
        dec_item_t r;
        r.data_bytes  = pk_bytes;
        r.byte_count  = pk_n[3:0];
        r.last_of_run = 1'b0;
        r.stream_done = 1'b0;
        r.status      = dm_status;
        r.total_count = dm_produced[15:0];
        step_results.push_back(r);
        pk_bytes = '0;
        pk_n = 0;
    endtask

    task automatic emit_decoded(logic [7:0] b);
        dm_hist[dm_hist_ptr] = b;
        dm_hist_ptr++;
        if (dm_produced < 65535)
            dm_produced++;
        pk_bytes[8*pk_n +: 8] = b;
        pk_n++;
        if (pk_n >= BytesPerResult)
            flush_packer();
    endtask

    // Literal items run until one needs a record or the frame ends.
    task automatic walk_literals();
        int cnt;
        cnt = frame_count_of(dm_mask);
        while (dm_flag_idx < cnt && !dm_mask[dm_flag_idx])
        begin
            emit_decoded(dm_symbols[dm_flag_idx]);
            dm_flag_idx++;
        end
        if (dm_flag_idx < cnt)
            dm_phase = PH_REC_LEN;
        else if (cnt == FlagsPerFrame)
        begin
            dm_flag_idx = 0;
            dm_phase = PH_MASK_LO;
        end
        else
            dm_phase = PH_DONE;
    endtask

    task automatic restart_stream();
        dm_phase = PH_MASK_LO;
        dm_mask = '0;
        dm_sym_idx = 0;
        dm_flag_idx = 0;
        dm_len = '0;
        dm_hist_ptr = '0;
        dm_produced = 0;
        dm_status = ST_OK;
    endtask

    // Predicts the results of one accepted item and queues them.
    task automatic decode_item(cmp_item_t it);
        logic [7:0] b;
        int off;
        b = it.compressed_byte;
        step_results.delete();
        pk_bytes = '0;
        pk_n = 0;
        case (dm_phase)
            PH_MASK_LO:
            begin
                dm_mask = {8'h00, b};
                dm_phase = PH_MASK_HI;
            end
            PH_MASK_HI:
            begin
                dm_mask[15:8] = b;
                dm_flag_idx = 0;
                dm_sym_idx = 0;
                if (frame_count_of(dm_mask) > FlagsPerFrame)
                begin
                    dm_status = ST_BAD_COUNT;
                    dm_phase = PH_HALT;
                end
                else if (frame_count_of(dm_mask) == 0)
                    dm_phase = PH_DONE;
                else
                    dm_phase = PH_SYMBOLS;
            end
            PH_SYMBOLS:
            begin
                dm_symbols[dm_sym_idx] = b;
                dm_sym_idx++;
                if (dm_sym_idx >= FlagsPerFrame)
                begin
                    dm_sym_idx = 0;
                    dm_flag_idx = 0;
                    walk_literals();
                end
            end
            PH_REC_LEN:
            begin
                dm_len = b;
                dm_phase = PH_REC_OFF;
            end
            PH_REC_OFF:
            begin
                off = int'(b);
                if (off == 0 || off > dm_produced)
                begin
                    dm_status = ST_BAD_OFF;
                    dm_phase = PH_HALT;
                end
                else
                begin
                    for (int i = 0; i < int'(dm_len); i++)
                        emit_decoded(dm_hist[dm_hist_ptr - b]);
                    emit_decoded(dm_symbols[dm_flag_idx]);
                    dm_flag_idx++;
                    walk_literals();
                end
            end
            default:
            begin
            end
        endcase
        if (it.end_of_stream)
        begin
            if (dm_status == ST_OK && dm_phase != PH_MASK_LO && dm_phase != PH_DONE)
                dm_status = ST_TRUNC;
            if (pk_n > 0 || step_results.size() == 0)
                flush_packer();
            step_results[$].last_of_run = 1'b1;
            step_results[$].stream_done = 1'b1;
            step_results[$].status = dm_status;
            restart_stream();
        end
        else
        begin
            if (pk_n > 0)
                flush_packer();
            if (step_results.size() > 0)
                step_results[$].last_of_run = 1'b1;
        end
        foreach (step_results[k])
            expected_output.push_back(step_results[k]);
    endtask

    // ---------------------------------------------------------------- stimulus
    function automatic void push_byte(logic [7:0] b, bit eos = 1'b0);
        cmp_item_t it;
        it.compressed_byte = b;
        it.end_of_stream = eos;
        pending_bytes.push_back(it);
    endfunction

    // One full frame of random content. Offsets stay within what the stream
    // has decoded so far, so most frames decode all the way through.
    // A count other than 12 makes the frame the last one.
    function automatic int push_frame(int produced, int cnt, bit bad_offset);
        logic [11:0] flags;
        int n;
        int len;
        int off;
        flags = 12'($urandom);
        if ($urandom_range(0, 3) == 0)
            flags = 12'($urandom) & 12'($urandom);
        push_byte(flags[7:0]);
        push_byte({cnt[3:0], flags[11:8]});
        for (int i = 0; i < FlagsPerFrame; i++)
            push_byte(8'($urandom));
        n = produced;
        for (int i = 0; i < cnt; i++)
        begin
            if (!flags[i])
            begin
                n++;
                continue;
            end
            // Mostly short copies, now and then a long one of 200 to 255.
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(200, 255)
                                                : $urandom_range(0, 12);
            if (n == 0 || (bad_offset && $urandom_range(0, 2) == 0))
                off = (n == 0 || $urandom_range(0, 1)) ? 0 : ((n < 255) ? n + 1 : 0);
            else
                off = $urandom_range(1, (n < 255) ? n : 255);
            push_byte(len[7:0]);
            push_byte(off[7:0]);
            if (off == 0 || off > n)
                return -1;
            n += len + 1;
        end
        return n;
    endfunction

    // A well-formed stream: up to three full frames, a short closing frame,
    // sometimes trailing bytes, then the end marker. With small chance it is
    // cut short or broken.
    task automatic push_stream();
        int n;
        int frames;
        int mode;
        n = 0;
        frames = $urandom_range(0, 3);
        mode = $urandom_range(0, 9);
        for (int f = 0; f < frames && n >= 0; f++)
            n = push_frame(n, FlagsPerFrame, mode == 0);
        if (n < 0 || mode == 1)
        begin
            // Errored or truncated: trail off with noise.
            repeat ($urandom_range(0, 4)) push_byte(8'($urandom));
            push_byte(8'($urandom), 1'b1);
        end
        else if (mode == 2)
        begin
            // Count above the limit.
            push_byte(8'($urandom));
            push_byte({4'($urandom_range(13, 15)), 4'($urandom)});
            push_byte(8'($urandom), 1'b1);
        end
        else
        begin
            n = push_frame(n, $urandom_range(0, 11), mode == 3);
            repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
            push_byte(8'($urandom), 1'b1);
        end
    endtask

    initial
    begin
        stimulus_built = 1'b0;
        // Directed: an empty stream, a count of zero, a literal-only frame of
        // three with the unused flags clear and trailing bytes after it, a bad
        // offset of zero, a count too large and a truncated frame.
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF);
        push_byte(8'h0F, 1'b1);
        push_byte(8'h00);
        push_byte(8'h30);
        push_byte(8'h41);
        push_byte(8'h42);
        push_byte(8'h43);
        push_byte(8'h44);
        for (int i = 0; i < 8; i++)
            push_byte(8'hF0 + 8'(i));
        push_byte(8'hAA);
        push_byte(8'h02);
        push_byte(8'h10);
        for (int i = 0; i < 12; i++)
            push_byte(8'h11 * 8'(i));
        push_byte(8'hFF);
        push_byte(8'h01);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h01);
        push_byte(8'h10);
        for (int i = 0; i < 12; i++)
            push_byte(8'h80 + 8'(i));
        push_byte(8'h03);
        push_byte(8'h00, 1'b1);
        push_byte(8'h00);
        push_byte(8'hD0, 1'b1);
        push_byte(8'h00);
        push_byte(8'hC0);
        push_byte(8'h55, 1'b1);
        while (pending_bytes.size() < 160)
            push_stream();
        drain_point = pending_bytes.size();
        while (pending_bytes.size() < 320)
            push_stream();
        stimulus_built = 1'b1;
    end

    // ------------------------------------------------------------ reset, limit
    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        error_count = 0;
        restart_stream();
        for (int i = 0; i < WindowSize; i++)
            dm_hist[i] = '0;
        for (int i = 0; i < FlagsPerFrame; i++)
            dm_symbols[i] = '0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        // Idling stops for a stretch in the middle of the run.
        quiet_idle <= (cycle_count > 1500 && cycle_count < 3000);
        if (cycle_count >= CycleLimit)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        cycle_count = 0;
        quiet_idle = 1'b0;
    end

    // ------------------------------------------------------------------ driver
    int sent_count;
    initial
    begin
        cmp_valid = 1'b0;
        cmp_item = '0;
        dec_stall = 1'b0;
        sent_count = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && stimulus_built)
        begin
            if (cmp_valid && !cmp_stall)
            begin
                decode_item(cmp_item);
                pending_bytes.pop_front();
                sent_count++;
            end
            if (cmp_valid && cmp_stall)
            begin
                // Hold the stalled item.
            end
            else if (pending_bytes.size() == 0)
                cmp_valid <= 1'b0;
            else if (sent_count == drain_point && expected_output.size() != 0)
                cmp_valid <= 1'b0;
            else if (!quiet_idle && $urandom_range(0, 99) < 10)
                cmp_valid <= 1'b0;
            else
            begin
                cmp_valid <= 1'b1;
                cmp_item <= pending_bytes[0];
            end
            dec_stall <= !quiet_idle && ($urandom_range(0, 99) < 10);
        end
    end

    // ----------------------------------------------------------------- monitor
    always @(posedge clk)
    begin
        dec_item_t want;
        if (rst_n && dec_valid && !dec_stall)
        begin
            if (expected_output.size() == 0)
            begin
                $error("unexpected result: data_bytes %h", dec_item.data_bytes);
                error_count++;
            end
            else
            begin
                want = expected_output.pop_front();
                if (dec_item.data_bytes !== want.data_bytes)
                begin
                    $error("data_bytes: expected %h, got %h",
                           want.data_bytes, dec_item.data_bytes);
                    error_count++;
                end
                if (dec_item.byte_count !== want.byte_count)
                begin
                    $error("byte_count: expected %0d, got %0d",
                           want.byte_count, dec_item.byte_count);
                    error_count++;
                end
                if (dec_item.last_of_run !== want.last_of_run)
                begin
                    $error("last_of_run: expected %b, got %b",
                           want.last_of_run, dec_item.last_of_run);
                    error_count++;
                end
                if (dec_item.stream_done !== want.stream_done)
                begin
                    $error("stream_done: expected %b, got %b",
                           want.stream_done, dec_item.stream_done);
                    error_count++;
                end
                if (dec_item.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, dec_item.status);
                    error_count++;
                end
                if (dec_item.total_count !== want.total_count)
                begin
                    $error("total_count: expected %0d, got %0d",
                           want.total_count, dec_item.total_count);
                    error_count++;
                end
            end
        end
    end

    // --------------------------------------------------------------------- end
    initial
    begin
        wait (stimulus_built);
        wait (pending_bytes.size() == 0);
        while (expected_output.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (error_count == 0 && expected_output.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== lz_frame_decompressor.f =====
hw/rtl/lfd_pkg.sv
hw/rtl/lfd_ram.sv
hw/rtl/lfd_ctrl.sv
hw/rtl/lfd_dp.sv
hw/rtl/lz_frame_decompressor.sv
tb/sv/tb_lz_frame_decompressor.sv
